@@ rtl/core/fpri_pkg.sv @@
// ============================================================================
// fpri_pkg
// Shared types and constants for the reordering drop-tail descriptor queue.
// ============================================================================
package fpri_pkg;

    localparam int BYTES_W = 16;
    localparam int OUT_HANDLE_W = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CNT_W = 8;

    // Opcodes of an input item.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_DEQUEUED = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_IN_BYTES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUEUE_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REORDER_DEPTH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IN_SEQ_LENGTH = 2'd3;

    // Configuration reset values.
    localparam logic RST_LIMIT_IN_BYTES = 1'b0;
    localparam logic [31:0] RST_QUEUE_LIMIT = 32'd100;
    localparam logic [CNT_W-1:0] RST_REORDER_DEPTH = 8'd5;
    localparam logic [CNT_W-1:0] RST_IN_SEQ_LENGTH = 8'd3;

    typedef struct packed {
        logic             limit_in_bytes;
        logic [31:0]      queue_limit;
        logic [CNT_W-1:0] reorder_depth;
        logic [CNT_W-1:0] in_sequence_length;
    } cfg_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [OUT_HANDLE_W-1:0] handle;
        logic [BYTES_W-1:0]      bytes;
        logic                    was_held;
    } res_t;

endpackage

@@ rtl/core/fpri_desc_ram.sv @@
// ============================================================================
// fpri_desc_ram
// Single-port descriptor memory with a registered read port.
// ============================================================================
module fpri_desc_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/fpri_cfg_regs.sv @@
// ============================================================================
// fpri_cfg_regs
// Configuration register file written through its own valid/ready channel.
// ============================================================================
module fpri_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fpri_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fpri_pkg::CFG_DATA_W-1:0]  cfg_data,
    output fpri_pkg::cfg_t                   cfg
);
    import fpri_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit_in_bytes <= RST_LIMIT_IN_BYTES;
            cfg_reg.queue_limit <= RST_QUEUE_LIMIT;
            cfg_reg.reorder_depth <= RST_REORDER_DEPTH;
            cfg_reg.in_sequence_length <= RST_IN_SEQ_LENGTH;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LIMIT_IN_BYTES: cfg_reg.limit_in_bytes <= cfg_data[0];
                CFG_QUEUE_LIMIT:    cfg_reg.queue_limit <= cfg_data[31:0];
                CFG_REORDER_DEPTH:  cfg_reg.reorder_depth <= cfg_data[CNT_W-1:0];
                CFG_IN_SEQ_LENGTH:  cfg_reg.in_sequence_length <= cfg_data[CNT_W-1:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/fpri_queue_ctrl.sv @@
// ============================================================================
// fpri_queue_ctrl
// Sequencer for admission, hold and release; drives the descriptor memory.
// ============================================================================
module fpri_queue_ctrl #(
    parameter int FIFO_DEPTH = 128,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic                                      opcode,
    input  logic [15:0]                               packet_handle,
    input  logic [fpri_pkg::BYTES_W-1:0]              packet_bytes,
    input  fpri_pkg::cfg_t                            cfg,
    output logic                                      mem_we,
    output logic [$clog2(FIFO_DEPTH)-1:0]             mem_addr,
    output logic [HANDLE_BITS+fpri_pkg::BYTES_W-1:0]  mem_wdata,
    input  logic [HANDLE_BITS+fpri_pkg::BYTES_W-1:0]  mem_rdata,
    output fpri_pkg::res_t                            res,
    output logic                                      res_valid,
    input  logic                                      res_ready
);
    import fpri_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int EW = HANDLE_BITS + BYTES_W;
    localparam logic [AW-1:0] LAST_PTR = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(FIFO_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_HOLD_RD = 4'b0010,
        S_POP_RD  = 4'b0100,
        S_DONE    = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [31:0]      byte_total_reg, byte_total_next;
    logic             held_valid_reg, held_valid_next;
    logic [EW-1:0]    held_entry_reg, held_entry_next;
    logic [CNT_W-1:0] bypass_reg, bypass_next;
    logic [CNT_W-1:0] in_order_reg, in_order_next;
    res_t             res_reg, res_next;

    res_t                 fin_res;
    logic                 fin_valid;
    logic                 accept;
    logic                 drop;
    logic [32:0]          byte_sum;
    logic [HANDLE_BITS-1:0] rd_handle;
    logic [BYTES_W-1:0]   rd_bytes;
    logic [HANDLE_BITS-1:0] held_handle;
    logic [BYTES_W-1:0]   held_bytes;
    logic [AW-1:0]        head_inc;
    logic [AW-1:0]        tail_inc;

    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;

    assign rd_handle = mem_rdata[EW-1:BYTES_W];
    assign rd_bytes = mem_rdata[BYTES_W-1:0];
    assign held_handle = held_entry_reg[EW-1:BYTES_W];
    assign held_bytes = held_entry_reg[BYTES_W-1:0];

    assign head_inc = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;

    assign byte_sum = {1'b0, byte_total_reg} + 33'(packet_bytes);
    assign drop = (count_reg == DEPTH_CNT)
               || (!cfg.limit_in_bytes && (32'(count_reg) >= cfg.queue_limit))
               || (cfg.limit_in_bytes && (byte_sum >= {1'b0, cfg.queue_limit}));

    // Only one item is in flight, so a write never meets a pending read of
    // the same entry and the memory needs no forwarding path.
    always_comb
    begin
        state_next = state_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        count_next = count_reg;
        byte_total_next = byte_total_reg;
        held_valid_next = held_valid_reg;
        held_entry_next = held_entry_reg;
        bypass_next = bypass_reg;
        in_order_next = in_order_reg;
        res_next = res_reg;
        mem_we = 1'b0;
        mem_addr = head_reg;
        mem_wdata = {HANDLE_BITS'(packet_handle), packet_bytes};
        fin_valid = 1'b0;
        fin_res = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_ENQUEUE)
                    begin
                        fin_valid = 1'b1;
                        if (drop)
                        begin
                            fin_res.status = ST_DROPPED;
                        end
                        else
                        begin
                            fin_res.status = ST_ENQUEUED;
                            mem_we = 1'b1;
                            mem_addr = tail_reg;
                            tail_next = tail_inc;
                            count_next = count_reg + 1'b1;
                            byte_total_next = byte_total_reg + 32'(packet_bytes);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        fin_valid = 1'b1;
                        fin_res.status = ST_EMPTY;
                    end
                    else if (held_valid_reg && (bypass_reg == cfg.reorder_depth))
                    begin
                        fin_valid = 1'b1;
                        fin_res.status = ST_DEQUEUED;
                        fin_res.handle = OUT_HANDLE_W'(held_handle);
                        fin_res.bytes = held_bytes;
                        fin_res.was_held = 1'b1;
                        held_valid_next = 1'b0;
                        byte_total_next = byte_total_reg - 32'(held_bytes);
                        bypass_next = '0;
                        in_order_next = '0;
                    end
                    else
                    begin
                        // Read the front entry; it arrives in the next cycle.
                        head_next = head_inc;
                        count_next = count_reg - 1'b1;
                        if (!held_valid_reg && (in_order_reg == cfg.in_sequence_length))
                        begin
                            bypass_next = '0;
                            in_order_next = '0;
                            state_next = S_HOLD_RD;
                        end
                        else
                        begin
                            state_next = S_POP_RD;
                        end
                    end
                end
            end

            S_HOLD_RD:
            begin
                held_entry_next = mem_rdata;
                if (count_reg == '0)
                begin
                    // Nothing left behind the held packet: release it at once.
                    fin_valid = 1'b1;
                    fin_res.status = ST_DEQUEUED;
                    fin_res.handle = OUT_HANDLE_W'(rd_handle);
                    fin_res.bytes = rd_bytes;
                    fin_res.was_held = 1'b1;
                    byte_total_next = byte_total_reg - 32'(rd_bytes);
                end
                else
                begin
                    held_valid_next = 1'b1;
                    head_next = head_inc;
                    count_next = count_reg - 1'b1;
                    state_next = S_POP_RD;
                end
            end

            S_POP_RD:
            begin
                fin_valid = 1'b1;
                fin_res.status = ST_DEQUEUED;
                fin_res.handle = OUT_HANDLE_W'(rd_handle);
                fin_res.bytes = rd_bytes;
                byte_total_next = byte_total_reg - 32'(rd_bytes);
                if (held_valid_reg)
                begin
                    bypass_next = bypass_reg + 1'b1;
                end
                else
                begin
                    in_order_next = in_order_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A finished item goes straight to the output stage when it has room;
        // otherwise it parks here until the stage frees up.
        if (fin_valid)
        begin
            if (res_ready)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                res_next = fin_res;
                state_next = S_DONE;
            end
        end
    end

    assign res_valid = (state_reg == S_DONE) || fin_valid;
    assign res = (state_reg == S_DONE) ? res_reg : fin_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
            byte_total_reg <= '0;
            held_valid_reg <= 1'b0;
            bypass_reg <= '0;
            in_order_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            count_reg <= count_next;
            byte_total_reg <= byte_total_next;
            held_valid_reg <= held_valid_next;
            bypass_reg <= bypass_next;
            in_order_reg <= in_order_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_entry_reg <= held_entry_next;
        res_reg <= res_next;
    end

endmodule

@@ rtl/core/fpri_out_stage.sv @@
// ============================================================================
// fpri_out_stage
// Output register that decouples the result channel from the sequencer.
// ============================================================================
module fpri_out_stage (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fpri_pkg::res_t                        res,
    input  logic                                  res_valid,
    output logic                                  res_ready,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [1:0]                            status,
    output logic [fpri_pkg::OUT_HANDLE_W-1:0]     out_handle,
    output logic [fpri_pkg::BYTES_W-1:0]          out_bytes,
    output logic                                  out_was_held
);
    import fpri_pkg::*;

    logic out_valid_reg;
    res_t data_reg;

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = data_reg.status;
    assign out_handle = data_reg.handle;
    assign out_bytes = data_reg.bytes;
    assign out_was_held = data_reg.was_held;

endmodule

@@ rtl/core/fifo_packet_reorder_injector_unit.sv @@
// ============================================================================
// fifo_packet_reorder_injector_unit
// Path to the output register: an enqueue, an empty dequeue or a release of
// the held packet finishes in S_IDLE; a normal dequeue passes S_POP_RD, a hold
// that releases at once passes S_HOLD_RD, and a hold followed by a pop passes
// S_HOLD_RD then S_POP_RD (two reads). One item is in work at a time.
// Reset clears pointers, counters and hold state; memory contents are kept.
// ============================================================================
module fifo_packet_reorder_injector_unit #(
    parameter int FIFO_DEPTH = 128,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  opcode,
    input  logic [15:0]                           packet_handle,
    input  logic [fpri_pkg::BYTES_W-1:0]          packet_bytes,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [1:0]                            status,
    output logic [fpri_pkg::OUT_HANDLE_W-1:0]     out_handle,
    output logic [fpri_pkg::BYTES_W-1:0]          out_bytes,
    output logic                                  out_was_held,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fpri_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [fpri_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import fpri_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int EW = HANDLE_BITS + BYTES_W;

    cfg_t          cfg;
    res_t          res;
    logic          res_valid;
    logic          res_ready;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [EW-1:0] mem_wdata;
    logic [EW-1:0] mem_rdata;

    fpri_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fpri_desc_ram #(
        .DEPTH (FIFO_DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    fpri_queue_ctrl #(
        .FIFO_DEPTH  (FIFO_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .packet_handle (packet_handle),
        .packet_bytes  (packet_bytes),
        .cfg           (cfg),
        .mem_we        (mem_we),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .mem_rdata     (mem_rdata),
        .res           (res),
        .res_valid     (res_valid),
        .res_ready     (res_ready)
    );

    fpri_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .res          (res),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_handle   (out_handle),
        .out_bytes    (out_bytes),
        .out_was_held (out_was_held)
    );

endmodule
